// ----- hdl/lant_pkg.sv -----
package lant_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 7;
    localparam int unsigned IN_DATA_W   = 16;
    localparam int unsigned IN_USER_W   = 2;
    localparam int unsigned OUT_DATA_W  = 16;
    localparam int unsigned POS_W       = 6;

    localparam logic [CFG_INDEX_W-1:0] REG_BOARD_ROWS    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BOARD_COLS    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_START_ROW     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_START_COL     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_START_HEADING = 3'd4;

    localparam logic [IN_USER_W-1:0] KIND_WRITE   = 2'd0;
    localparam logic [IN_USER_W-1:0] KIND_STEP    = 2'd1;
    localparam logic [IN_USER_W-1:0] KIND_RESTART = 2'd2;

    localparam logic [1:0] HEAD_NORTH = 2'd0;
    localparam logic [1:0] HEAD_EAST  = 2'd1;
    localparam logic [1:0] HEAD_SOUTH = 2'd2;
    localparam logic [1:0] HEAD_WEST  = 2'd3;

    localparam logic [CFG_DATA_W-1:0] BOARD_SIZE_RESET = 7'd64;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_STEP
    } state_t;

    typedef struct packed {
        logic clr;
        logic acc;
        logic wb;
    } cmd_t;

    typedef struct packed {
        logic clr_last;
        logic in_step;
    } sts_t;

endpackage

// ----- hdl/langton_ant_stepper_unit.sv -----
// Langton's ant on a toroidal board of MAX_ROWS by MAX_COLS one-bit cells held in a
// single-port board memory. After reset the block clears every cell of the board
// with s_tready low; configuration writes are taken during that time. A write,
// restart or unused-kind transfer loads its result register when it is taken. For a
// step transfer the board cell under the ant is read into a register, and the cell is
// then written back flipped in ST_STEP, which also loads the result and holds s_tready
// low. Every input transfer yields exactly one result transfer, and a new input is
// taken once the result register is empty or being drained in the same cycle.
module langton_ant_stepper_unit #(
    parameter int unsigned MAX_ROWS = 64,
    parameter int unsigned MAX_COLS = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [lant_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lant_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [5:0] cell_row, [11:6] cell_col, [12] cell_black, [15:13] zero
    input  logic [lant_pkg::IN_DATA_W-1:0]      s_tdata,
    // [1:0] kind
    input  logic [lant_pkg::IN_USER_W-1:0]      s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [5:0] ant_row, [11:6] ant_col, [13:12] ant_heading, [14] found_black, [15] zero
    output logic [lant_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import lant_pkg::*;

    cmd_t cmd;
    sts_t sts;

    lant_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    lant_datapath #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd       (cmd),
        .sts       (sts),
        .m_tdata   (m_tdata)
    );

endmodule

// ----- hdl/lant_ctrl.sv -----
module lant_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  logic           m_tready,
    input  lant_pkg::sts_t sts,
    output lant_pkg::cmd_t cmd
);
    import lant_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd          = '0;
        m_valid_next = m_valid_reg && !m_tready;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr = 1'b1;
                if (sts.clr_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = !m_valid_reg || m_tready;
                cmd.acc  = s_tvalid && s_tready;
                if (cmd.acc) begin
                    if (sts.in_step) begin
                        state_next = ST_STEP;
                    end else begin
                        m_valid_next = 1'b1;
                    end
                end
            end
            ST_STEP: begin
                cmd.wb       = 1'b1;
                m_valid_next = 1'b1;
                state_next   = ST_IDLE;
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    assign m_tvalid = m_valid_reg;

endmodule

// ----- hdl/lant_datapath.sv -----
module lant_datapath #(
    parameter int unsigned MAX_ROWS = 64,
    parameter int unsigned MAX_COLS = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [lant_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [lant_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [lant_pkg::IN_DATA_W-1:0]      s_tdata,
    input  logic [lant_pkg::IN_USER_W-1:0]      s_tuser,
    input  lant_pkg::cmd_t                      cmd,
    output lant_pkg::sts_t                      sts,
    output logic [lant_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import lant_pkg::*;

    localparam int unsigned RW    = $clog2(MAX_ROWS);
    localparam int unsigned CW    = $clog2(MAX_COLS);
    localparam int unsigned RXW   = ($clog2(MAX_ROWS + 1) > 7) ? $clog2(MAX_ROWS + 1) : 7;
    localparam int unsigned CXW   = ($clog2(MAX_COLS + 1) > 7) ? $clog2(MAX_COLS + 1) : 7;
    localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
    localparam int unsigned AW    = $clog2(DEPTH);

    logic [CFG_DATA_W-1:0] board_rows_reg;
    logic [CFG_DATA_W-1:0] board_cols_reg;
    logic [POS_W-1:0]      start_row_reg;
    logic [POS_W-1:0]      start_col_reg;
    logic [1:0]            start_heading_reg;

    logic [RW-1:0] ant_row_reg;
    logic [RW-1:0] ant_row_next;
    logic [CW-1:0] ant_col_reg;
    logic [CW-1:0] ant_col_next;
    logic [1:0]    heading_reg;
    logic [1:0]    heading_next;

    logic [RW-1:0] step_row_reg;
    logic [CW-1:0] step_col_reg;
    logic [AW-1:0] step_addr_reg;
    logic          rd_bit_reg;
    logic [AW-1:0] clr_addr_reg;

    logic [POS_W-1:0] out_row_reg;
    logic [POS_W-1:0] out_col_reg;
    logic [1:0]       out_heading_reg;
    logic             out_found_reg;

    logic mem [DEPTH];

    logic [POS_W-1:0] in_row;
    logic [POS_W-1:0] in_col;
    logic             in_black;
    logic             is_step;
    logic             is_write;
    logic             is_restart;
    logic             in_range;

    logic [RXW-1:0] rows_raw;
    logic [CXW-1:0] cols_raw;
    logic [RXW-1:0] rows_eff;
    logic [CXW-1:0] cols_eff;
    logic [RXW-1:0] cur_row;
    logic [CXW-1:0] cur_col;
    logic [RXW-1:0] rst_row;
    logic [CXW-1:0] rst_col;
    logic [RXW-1:0] row_x;
    logic [CXW-1:0] col_x;
    logic [AW-1:0]  cur_addr;
    logic [AW-1:0]  in_addr;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic          mem_wdata;
    logic          out_load;

    assign in_row     = s_tdata[5:0];
    assign in_col     = s_tdata[11:6];
    assign in_black   = s_tdata[12];
    assign is_step    = (s_tuser == KIND_STEP);
    assign is_write   = (s_tuser == KIND_WRITE);
    assign is_restart = (s_tuser == KIND_RESTART);

    assign rows_raw = RXW'(board_rows_reg);
    assign cols_raw = CXW'(board_cols_reg);

    always_comb begin
        if (rows_raw == '0) begin
            rows_eff = RXW'(1);
        end else if (rows_raw > RXW'(MAX_ROWS)) begin
            rows_eff = RXW'(MAX_ROWS);
        end else begin
            rows_eff = rows_raw;
        end
        if (cols_raw == '0) begin
            cols_eff = CXW'(1);
        end else if (cols_raw > CXW'(MAX_COLS)) begin
            cols_eff = CXW'(MAX_COLS);
        end else begin
            cols_eff = cols_raw;
        end
    end

    // The ant can sit outside the board after the board size shrinks.
    assign cur_row = (RXW'(ant_row_reg) >= rows_eff) ? rows_eff - RXW'(1) : RXW'(ant_row_reg);
    assign cur_col = (CXW'(ant_col_reg) >= cols_eff) ? cols_eff - CXW'(1) : CXW'(ant_col_reg);
    assign rst_row = (RXW'(start_row_reg) >= rows_eff) ? rows_eff - RXW'(1)
                                                       : RXW'(start_row_reg);
    assign rst_col = (CXW'(start_col_reg) >= cols_eff) ? cols_eff - CXW'(1)
                                                       : CXW'(start_col_reg);

    assign cur_addr = AW'(cur_row[RW-1:0]) * AW'(MAX_COLS) + AW'(cur_col[CW-1:0]);
    assign in_range = (RXW'(in_row) < RXW'(MAX_ROWS)) && (CXW'(in_col) < CXW'(MAX_COLS));
    assign in_addr  = AW'(in_row) * AW'(MAX_COLS) + AW'(in_col);

    assign sts.clr_last = (clr_addr_reg == AW'(DEPTH - 1));
    assign sts.in_step  = is_step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            board_rows_reg    <= BOARD_SIZE_RESET;
            board_cols_reg    <= BOARD_SIZE_RESET;
            start_row_reg     <= '0;
            start_col_reg     <= '0;
            start_heading_reg <= HEAD_NORTH;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_BOARD_ROWS:    board_rows_reg    <= cfg_wdata;
                REG_BOARD_COLS:    board_cols_reg    <= cfg_wdata;
                REG_START_ROW:     start_row_reg     <= cfg_wdata[POS_W-1:0];
                REG_START_COL:     start_col_reg     <= cfg_wdata[POS_W-1:0];
                REG_START_HEADING: start_heading_reg <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clr && !sts.clr_last) begin
            clr_addr_reg <= clr_addr_reg + AW'(1);
        end
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = step_addr_reg;
        mem_wdata = !rd_bit_reg;
        if (cmd.clr) begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = 1'b0;
        end else if (cmd.acc && is_write && in_range) begin
            mem_we    = 1'b1;
            mem_waddr = in_addr;
            mem_wdata = in_black;
        end else if (cmd.wb) begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.acc && is_step) begin
            rd_bit_reg <= mem[cur_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.acc && is_step) begin
            step_row_reg  <= cur_row[RW-1:0];
            step_col_reg  <= cur_col[CW-1:0];
            step_addr_reg <= cur_addr;
        end
    end

    // White turns the ant right, black turns it left; then it moves with wraparound.
    always_comb begin
        ant_row_next = ant_row_reg;
        ant_col_next = ant_col_reg;
        heading_next = heading_reg;
        row_x        = RXW'(step_row_reg);
        col_x        = CXW'(step_col_reg);
        if (cmd.wb) begin
            heading_next = rd_bit_reg ? heading_reg - 2'd1 : heading_reg + 2'd1;
            ant_row_next = step_row_reg;
            ant_col_next = step_col_reg;
            case (heading_next)
                HEAD_NORTH: begin
                    row_x        = (step_row_reg != '0) ? row_x - RXW'(1) : rows_eff - RXW'(1);
                    ant_row_next = row_x[RW-1:0];
                end
                HEAD_EAST: begin
                    col_x        = (col_x + CXW'(1) < cols_eff) ? col_x + CXW'(1) : '0;
                    ant_col_next = col_x[CW-1:0];
                end
                HEAD_SOUTH: begin
                    row_x        = (row_x + RXW'(1) < rows_eff) ? row_x + RXW'(1) : '0;
                    ant_row_next = row_x[RW-1:0];
                end
                default: begin
                    col_x        = (step_col_reg != '0) ? col_x - CXW'(1) : cols_eff - CXW'(1);
                    ant_col_next = col_x[CW-1:0];
                end
            endcase
        end else if (cmd.acc && is_restart) begin
            ant_row_next = rst_row[RW-1:0];
            ant_col_next = rst_col[CW-1:0];
            heading_next = start_heading_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ant_row_reg <= '0;
            ant_col_reg <= '0;
            heading_reg <= HEAD_NORTH;
        end else begin
            ant_row_reg <= ant_row_next;
            ant_col_reg <= ant_col_next;
            heading_reg <= heading_next;
        end
    end

    assign out_load = (cmd.acc && !is_step) || cmd.wb;

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_row_reg     <= POS_W'(ant_row_next);
            out_col_reg     <= POS_W'(ant_col_next);
            out_heading_reg <= heading_next;
            out_found_reg   <= cmd.wb && rd_bit_reg;
        end
    end

    assign m_tdata = {1'b0, out_found_reg, out_heading_reg, out_col_reg, out_row_reg};

endmodule

// ----- hdl/lant_checker.sv -----
module lant_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [lant_pkg::IN_USER_W-1:0]      s_tuser,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [lant_pkg::OUT_DATA_W-1:0]     m_tdata
);
    import lant_pkg::*;

    logic in_xfer;

    assign in_xfer = s_tvalid && s_tready;

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("result or input channel active right after reset");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed or was dropped");

    a_short_item: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer && s_tuser != KIND_STEP |=> m_tvalid && !m_tdata[14])
        else $error("non-step transfer gave no result or a found cell");

    a_step_item: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer && s_tuser == KIND_STEP |=> !m_tvalid && !s_tready ##1 m_tvalid)
        else $error("step transfer did not give its result in the second cycle");

endmodule

bind langton_ant_stepper_unit lant_checker u_lant_checker (.*);

// ----- tb/tb_top.sv -----
module tb_top;
    import lant_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 250000;
    localparam int unsigned BOARD_DIM = 64;
    localparam int unsigned RANDOM_ITEMS = 1250;
    localparam int unsigned MAX_WAIT = 12;
    localparam logic [IN_USER_W-1:0] KIND_UNUSED = 2'd3;

    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [1:0]       heading;
        logic             found;
    } ant_report_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;
    logic [IN_USER_W-1:0]   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;

    ant_report_t pending_ant_reports[$];
    bit          board_img [BOARD_DIM][BOARD_DIM];
    logic [6:0]  rows_cfg, cols_cfg;
    logic [5:0]  start_row_cfg, start_col_cfg;
    logic [1:0]  start_head_cfg;
    logic [5:0]  ant_row, ant_col;
    logic [1:0]  ant_head;
    int unsigned errors;
    int unsigned cycles;
    bit          no_idle;

    langton_ant_stepper_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (errors < 40) begin
            $display("cycle %0d: %s: got %0d, expected %0d", cycles, what, got, want);
        end
        errors++;
    endtask

    function automatic int unsigned span(input logic [6:0] v);
        if (v == 0) return 1;
        if (v > BOARD_DIM) return BOARD_DIM;
        return 32'(v);
    endfunction

    function automatic logic [5:0] pin(input logic [5:0] p, input int unsigned size);
        return (p >= size) ? 6'(size - 1) : p;
    endfunction

    function automatic ant_report_t advance_ant(input logic [IN_USER_W-1:0] kind,
                                                input logic [5:0] r, input logic [5:0] c,
                                                input logic b);
        int unsigned rows, cols;
        logic [5:0]  ar, ac;
        logic        found;
        ant_report_t rep;
        rows = span(rows_cfg);
        cols = span(cols_cfg);
        found = 1'b0;
        case (kind)
            KIND_WRITE: begin
                board_img[r][c] = b;
            end
            KIND_STEP: begin
                ar = pin(ant_row, rows);
                ac = pin(ant_col, cols);
                found = board_img[ar][ac];
                board_img[ar][ac] = ~found;
                ant_head = found ? ant_head - 2'd1 : ant_head + 2'd1;
                case (ant_head)
                    HEAD_NORTH: ar = (ar > 0) ? ar - 6'd1 : 6'(rows - 1);
                    HEAD_EAST:  ac = (ac + 1 < cols) ? ac + 6'd1 : 6'd0;
                    HEAD_SOUTH: ar = (ar + 1 < rows) ? ar + 6'd1 : 6'd0;
                    default:    ac = (ac > 0) ? ac - 6'd1 : 6'(cols - 1);
                endcase
                ant_row = ar;
                ant_col = ac;
            end
            KIND_RESTART: begin
                ant_row = pin(start_row_cfg, rows);
                ant_col = pin(start_col_cfg, cols);
                ant_head = start_head_cfg;
            end
            default: ;
        endcase
        rep.row = ant_row;
        rep.col = ant_col;
        rep.heading = ant_head;
        rep.found = found;
        return rep;
    endfunction

    function automatic logic [6:0] draw_size();
        case ($urandom_range(0, 9))
            0: return 7'(BOARD_DIM);
            1: return 7'($urandom_range(0, 127));
            default: return 7'($urandom_range(1, 8));
        endcase
    endfunction

    task automatic put_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
    endtask

    task automatic load_settings(input logic [6:0] rows, input logic [6:0] cols,
                                 input logic [5:0] srow, input logic [5:0] scol,
                                 input logic [1:0] shead);
        put_reg(REG_BOARD_ROWS, rows);
        put_reg(REG_BOARD_COLS, cols);
        put_reg(REG_START_ROW, 7'(srow));
        put_reg(REG_START_COL, 7'(scol));
        put_reg(REG_START_HEADING, 7'(shead));
        cfg_we <= 1'b0;
        rows_cfg = rows;
        cols_cfg = cols;
        start_row_cfg = srow;
        start_col_cfg = scol;
        start_head_cfg = shead;
    endtask

    task automatic send_item(input logic [IN_USER_W-1:0] kind, input logic [5:0] r,
                             input logic [5:0] c, input logic b);
        int unsigned gap;
        gap = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= kind;
        s_tdata <= {3'b000, b, c, r};
        do @(posedge aclk); while (!s_tready);
        pending_ant_reports.push_back(advance_ant(kind, r, c, b));
    endtask

    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_ant_reports.size() > 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    initial begin : result_monitor
        int unsigned hold;
        ant_report_t got, want;
        hold = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                got.row = m_tdata[5:0];
                got.col = m_tdata[11:6];
                got.heading = m_tdata[13:12];
                got.found = m_tdata[14];
                if (pending_ant_reports.size() == 0) begin
                    report_mismatch("result transfer with nothing expected", 32'(got), 0);
                end else begin
                    want = pending_ant_reports.pop_front();
                    if (got.row !== want.row) begin
                        report_mismatch("ant_row", 32'(got.row), 32'(want.row));
                    end
                    if (got.col !== want.col) begin
                        report_mismatch("ant_col", 32'(got.col), 32'(want.col));
                    end
                    if (got.heading !== want.heading) begin
                        report_mismatch("ant_heading", 32'(got.heading), 32'(want.heading));
                    end
                    if (got.found !== want.found) begin
                        report_mismatch("found_black", 32'(got.found), 32'(want.found));
                    end
                end
                hold = no_idle ? 0 : $urandom_range(0, MAX_WAIT);
            end
            if (hold > 0) begin
                m_tready <= 1'b0;
                hold--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic test_reset_state();
        send_item(KIND_UNUSED, 6'h3f, 6'h3f, 1'b1);
        send_item(KIND_STEP, 6'd0, 6'd0, 1'b0);
        settle();
    endtask

    task automatic test_edge_wrap();
        load_settings(7'd64, 7'd64, 6'd0, 6'd0, HEAD_EAST);
        send_item(KIND_RESTART, 6'd0, 6'd0, 1'b0);
        send_item(KIND_STEP, 6'd0, 6'd0, 1'b0);
        settle();
        load_settings(7'd64, 7'd64, 6'd63, 6'd63, HEAD_WEST);
        send_item(KIND_WRITE, 6'd63, 6'd63, 1'b1);
        send_item(KIND_RESTART, 6'd0, 6'd0, 1'b0);
        send_item(KIND_STEP, 6'd0, 6'd0, 1'b0);
        settle();
        load_settings(7'd64, 7'd64, 6'd0, 6'd63, HEAD_NORTH);
        send_item(KIND_RESTART, 6'd0, 6'd0, 1'b0);
        send_item(KIND_STEP, 6'd0, 6'd0, 1'b0);
        settle();
        load_settings(7'd64, 7'd64, 6'd0, 6'd0, HEAD_SOUTH);
        send_item(KIND_RESTART, 6'd0, 6'd0, 1'b0);
        send_item(KIND_STEP, 6'd0, 6'd0, 1'b0);
        settle();
    endtask

    task automatic test_size_clamp();
        load_settings(7'd0, 7'd127, 6'd40, 6'd63, HEAD_EAST);
        send_item(KIND_RESTART, 6'd0, 6'd0, 1'b0);
        send_item(KIND_STEP, 6'd0, 6'd0, 1'b0);
        settle();
        load_settings(7'd65, 7'd0, 6'd63, 6'd0, HEAD_WEST);
        send_item(KIND_STEP, 6'd0, 6'd0, 1'b0);
        send_item(KIND_RESTART, 6'd0, 6'd0, 1'b0);
        settle();
    endtask

    task automatic test_one_cell();
        load_settings(7'd1, 7'd1, 6'd63, 6'd63, HEAD_NORTH);
        send_item(KIND_RESTART, 6'd0, 6'd0, 1'b0);
        send_item(KIND_STEP, 6'd0, 6'd0, 1'b0);
        send_item(KIND_STEP, 6'd0, 6'd0, 1'b0);
        send_item(KIND_WRITE, 6'd63, 6'd63, 1'b1);
        send_item(KIND_WRITE, 6'd0, 6'd0, 1'b1);
        send_item(KIND_STEP, 6'd0, 6'd0, 1'b0);
        send_item(KIND_UNUSED, 6'h3f, 6'h3f, 1'b1);
        settle();
    endtask

    task automatic test_random();
        int unsigned sent, batch, pick;
        logic [IN_USER_W-1:0] kind;
        logic [5:0] r, c;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            load_settings(draw_size(), draw_size(),
                          ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 7))
                                                      : 6'($urandom_range(0, 63)),
                          ($urandom_range(0, 1) == 0) ? 6'($urandom_range(0, 7))
                                                      : 6'($urandom_range(0, 63)),
                          2'($urandom_range(0, 3)));
            no_idle = ($urandom_range(0, 3) == 0);
            batch = $urandom_range(20, 60);
            repeat (batch) begin
                pick = $urandom_range(0, 99);
                if (pick < 70) kind = KIND_STEP;
                else if (pick < 83) kind = KIND_WRITE;
                else if (pick < 93) kind = KIND_RESTART;
                else kind = KIND_UNUSED;
                if (kind == KIND_WRITE && $urandom_range(0, 3) != 0) begin
                    r = 6'($urandom_range(0, span(rows_cfg) - 1));
                    c = 6'($urandom_range(0, span(cols_cfg) - 1));
                end else begin
                    r = 6'($urandom_range(0, 63));
                    c = 6'($urandom_range(0, 63));
                end
                send_item(kind, r, c, 1'($urandom_range(0, 1)));
                sent++;
            end
            settle();
            no_idle = 1'b0;
        end
    endtask

    initial begin
        aclk = 1'b0;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        errors = 0;
        cycles = 0;
        no_idle = 1'b0;
        rows_cfg = BOARD_SIZE_RESET;
        cols_cfg = BOARD_SIZE_RESET;
        start_row_cfg = '0;
        start_col_cfg = '0;
        start_head_cfg = HEAD_NORTH;
        ant_row = '0;
        ant_col = '0;
        ant_head = HEAD_NORTH;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_state();
        test_edge_wrap();
        test_size_clamp();
        test_one_cell();
        test_random();

        settle();
        repeat (16) @(posedge aclk);
        if (pending_ant_reports.size() != 0) begin
            report_mismatch("results never delivered", pending_ant_reports.size(), 0);
        end
        if (errors == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/lant_pkg.sv
hdl/lant_ctrl.sv
hdl/lant_datapath.sv
hdl/langton_ant_stepper_unit.sv
hdl/lant_checker.sv
tb/tb_top.sv
